// ===== hw/rtl/base64_encoder_line_wrap_defines.svh =====
// Assertion macros for the encoder modules; b64lw_back is the only one that uses them.
`ifndef BASE64_ENCODER_LINE_WRAP_DEFINES_SVH
`define BASE64_ENCODER_LINE_WRAP_DEFINES_SVH

`ifndef SYNTHESIS
`define B64LW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define B64LW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define B64LW_ASSERT(label, clk, rst_n, prop, msg)
`define B64LW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/b64lw_pkg.sv =====
package b64lw_pkg;

    localparam int LineLenW = 10;
    localparam logic [LineLenW-1:0] LineLengthReset = 10'd76;
    localparam int QueueDepth = 2;

    localparam logic [7:0] PadChar = 8'd61;
    localparam logic [7:0] NewlineChar = 8'd10;

    // One input byte turns into one to four characters.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            last;
    } t_bundle;

    function automatic logic [7:0] encode_sextet(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'd65 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'd71 + {2'b00, v};
        end else if (v < 6'd62) begin
            c = {2'b00, v} - 8'd4;
        end else if (v == 6'd62) begin
            c = 8'd43;
        end else begin
            c = 8'd47;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/b64lw_front.sv =====
module b64lw_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    output b64lw_pkg::t_bundle  o_bundle
);

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase_e;

    t_phase_e   r_phase, n_phase;
    logic [3:0] r_held, n_held;

    always_comb begin
        o_bundle = '0;
        n_phase  = r_phase;
        n_held   = r_held;
        o_bundle.last = i_last_byte;
        unique case (r_phase)
            PH_SECOND: begin
                o_bundle.chars[0] = b64lw_pkg::encode_sextet({r_held[1:0], i_data_byte[7:4]});
                o_bundle.chars[1] = b64lw_pkg::encode_sextet({i_data_byte[3:0], 2'b00});
                o_bundle.chars[2] = b64lw_pkg::PadChar;
                o_bundle.last_idx = i_last_byte ? 2'd2 : 2'd0;
                n_held  = i_data_byte[3:0];
                n_phase = PH_THIRD;
            end
            PH_THIRD: begin
                o_bundle.chars[0] = b64lw_pkg::encode_sextet({r_held, i_data_byte[7:6]});
                o_bundle.chars[1] = b64lw_pkg::encode_sextet(i_data_byte[5:0]);
                o_bundle.last_idx = 2'd1;
                n_held  = 4'd0;
                n_phase = PH_FIRST;
            end
            default: begin
                o_bundle.chars[0] = b64lw_pkg::encode_sextet(i_data_byte[7:2]);
                o_bundle.chars[1] = b64lw_pkg::encode_sextet({i_data_byte[1:0], 4'b0000});
                o_bundle.chars[2] = b64lw_pkg::PadChar;
                o_bundle.chars[3] = b64lw_pkg::PadChar;
                o_bundle.last_idx = i_last_byte ? 2'd3 : 2'd0;
                n_held  = {2'b00, i_data_byte[1:0]};
                n_phase = PH_SECOND;
            end
        endcase
        if (i_last_byte) begin
            n_held  = 4'd0;
            n_phase = PH_FIRST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_held  <= 4'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

// ===== hw/rtl/b64lw_fifo.sv =====
module b64lw_fifo #(
    parameter int DEPTH = b64lw_pkg::QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64lw_pkg::t_bundle  i_wdata,
    output logic                o_full,
    input  logic                i_pop,
    output b64lw_pkg::t_bundle  o_rdata,
    output logic                o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    b64lw_pkg::t_bundle r_slot [DEPTH];
    logic [AW-1:0]      r_wr_ptr, r_rd_ptr;
    logic [AW:0]        r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/b64lw_back.sv =====
`include "base64_encoder_line_wrap_defines.svh"

module b64lw_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [b64lw_pkg::LineLenW-1:0]      i_line_length,
    input  logic                                i_bundle_empty,
    input  b64lw_pkg::t_bundle                  i_bundle,
    output logic                                o_bundle_pop,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic [7:0]                          o_out_char,
    output logic                                o_last_char
);

    logic [1:0]                     r_idx;
    logic                           r_nl_done;
    logic [b64lw_pkg::LineLenW-1:0] r_line_count;
    logic                           r_out_valid;
    logic [7:0]                     r_out_char;
    logic                           r_out_last;

    logic advance, emit, need_nl, is_final, emit_nl, emit_char, emit_last;

    assign advance   = !r_out_valid || i_pop;
    assign emit      = advance && !i_bundle_empty;
    assign need_nl   = (i_line_length != '0) && (r_line_count == i_line_length) && !r_nl_done;
    assign is_final  = (r_idx == i_bundle.last_idx);
    assign emit_nl   = emit && need_nl;
    assign emit_char = emit && !need_nl;
    assign emit_last = emit_char && is_final && i_bundle.last;

    assign o_bundle_pop = emit_char && is_final;
    assign o_empty      = !r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_last_char  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (emit_nl) begin
            r_out_char <= b64lw_pkg::NewlineChar;
            r_out_last <= 1'b0;
        end else if (emit_char) begin
            r_out_char <= i_bundle.chars[r_idx];
            r_out_last <= is_final && i_bundle.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_idx        <= 2'd0;
            r_nl_done    <= 1'b0;
            r_line_count <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= !i_bundle_empty;
            end
            if (emit_nl) begin
                r_nl_done    <= 1'b1;
                r_line_count <= b64lw_pkg::LineLenW'(1);
            end else if (emit_char) begin
                r_nl_done <= 1'b0;
                r_idx     <= is_final ? 2'd0 : r_idx + 2'd1;
                if (is_final && i_bundle.last) begin
                    r_line_count <= '0;
                end else if (!r_nl_done) begin
                    r_line_count <= r_line_count + 1'b1;
                end
            end
        end
    end

    `B64LW_ASSERT(a_idx_in_bundle, i_clk, i_rst_n, !i_bundle_empty |-> r_idx <= i_bundle.last_idx, "Character index ran past the end of its bundle.")
    `B64LW_ASSERT(a_count_after_nl, i_clk, i_rst_n, emit_nl |=> (r_line_count == 1 && r_nl_done), "Line count is not one after a newline.")
    `B64LW_ASSERT(a_count_after_last, i_clk, i_rst_n, emit_last |=> (r_line_count == 0 && r_out_last && r_out_valid), "Line count did not restart after the final character.")

endmodule

// ===== hw/rtl/base64_encoder_line_wrap.sv =====
// Base64 encoder with line wrapping. An accepted byte's bundle is written into the queue, and
// its characters are then registered in the output stage, which waits for the consumer's pop.
// Throughput: one character or newline per cycle from the output stage while pop drains it,
// so a byte yields up to eight outputs (four characters, each after a newline at line length one).
// Reset (synchronous, active low) clears the queue and group state, line length 76.
module base64_encoder_line_wrap #(
    parameter int QUEUE_DEPTH = b64lw_pkg::QueueDepth
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [b64lw_pkg::LineLenW-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_out_char,
    output logic                           o_last_char
);

    logic [b64lw_pkg::LineLenW-1:0] r_line_length;
    b64lw_pkg::t_bundle             front_bundle, queue_bundle;
    logic                           accept, queue_empty, queue_pop;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= b64lw_pkg::LineLengthReset;
        end else if (i_cfg_we) begin
            r_line_length <= i_cfg_data;
        end
    end

    b64lw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_bundle    (front_bundle)
    );

    b64lw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_bundle),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_rdata (queue_bundle),
        .o_empty (queue_empty)
    );

    b64lw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_line_length  (r_line_length),
        .i_bundle_empty (queue_empty),
        .i_bundle       (queue_bundle),
        .o_bundle_pop   (queue_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_char     (o_out_char),
        .o_last_char    (o_last_char)
    );

endmodule
